// ----- hdl/hufbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufbp_pkg
// types and constants of the huffman table bit packer
// ----------------------------------------------------------------------------
package hufbp_pkg;

    localparam int MODE_W    = 2;
    localparam int IDX_W     = 9;
    localparam int LEN_W     = 6;
    localparam int VAL_W     = 32;
    localparam int SAMPLE_W  = 8;
    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;

    localparam int TABLE_ENTRIES = 257;
    localparam int ENTRY_W       = LEN_W + VAL_W;
    localparam logic [IDX_W-1:0] END_SLOT = 9'd256;

    // input tdata layout, lowest field first
    localparam int IDX_LSB    = 0;
    localparam int LEN_LSB    = IDX_LSB + IDX_W;
    localparam int VAL_LSB    = LEN_LSB + LEN_W;
    localparam int SAMPLE_LSB = VAL_LSB + VAL_W;
    localparam int IN_BITS    = SAMPLE_LSB + SAMPLE_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_END    = 2'd2
    } t_mode;

endpackage

// ----- hdl/hufbp_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufbp_ram
// single port synchronous ram with registered read data
// ----------------------------------------------------------------------------
module hufbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 257,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/huffman_table_bit_packer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_bit_packer_top
// table driven huffman encoder packing codes into bytes, with end code flush
//
// channel  dir  tdata                                         tuser     tlast
// s        in   entry_index, code_length, code_value, sample  mode      -
// m        out  out_byte                                      status    last
//
// an item is taken every cycle while the emitter keeps up; the table ram
// is read on accepting an encode or end item; its registered data loads
// the byte emitter, which moves one byte (or one partial absorb, or one
// error) per cycle while the m side is free. an encode emits its bytes
// and keeps left over bits pending, an end pads them out to a byte, and an
// error gives one status byte. after reset a clearing pass writes all 257
// table entries with o_s_tready low. a stalled m side holds the emitter.
// ----------------------------------------------------------------------------
module huffman_table_bit_packer_top #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // entry_index, code_length, code_value, sample, zero pad
    input  logic [hufbp_pkg::IN_DATA_W-1:0] i_s_tdata,
    // mode
    input  logic [hufbp_pkg::MODE_W-1:0]    i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // out_byte
    output logic [hufbp_pkg::BYTE_W-1:0]    o_m_tdata,
    // status
    output logic [0:0]                     o_m_tuser,
    output logic                           o_m_tlast
);

    import hufbp_pkg::*;

    localparam int CW     = MAX_CODE_LEN;
    localparam int CW_EXT = (MAX_CODE_LEN > VAL_W) ? MAX_CODE_LEN : VAL_W;
    localparam int SH_W   = $clog2(CW_EXT + 1);
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_CODE_LEN);

    // input unpack
    t_mode              w_mode;
    logic [IDX_W-1:0]   w_index;
    logic [LEN_W-1:0]   w_len;
    logic [VAL_W-1:0]   w_val;
    logic [SAMPLE_W-1:0] w_sample;
    logic [LEN_W-1:0]   w_len_clamp;

    assign w_mode   = t_mode'(i_s_tuser);
    assign w_index  = i_s_tdata[IDX_LSB +: IDX_W];
    assign w_len    = i_s_tdata[LEN_LSB +: LEN_W];
    assign w_val    = i_s_tdata[VAL_LSB +: VAL_W];
    assign w_sample = i_s_tdata[SAMPLE_LSB +: SAMPLE_W];
    assign w_len_clamp = ({1'b0, w_len} > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : w_len;

    // control registers
    logic             r_clr_active;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_rd_valid;
    logic             r_rd_end;
    logic             r_busy;
    logic             r_err;
    logic             r_end;
    logic             r_o_valid;

    // payload registers
    logic [CW-1:0]     r_code;
    logic [LEN_W-1:0]  r_rem;
    logic [PEND_W-1:0] r_pend;
    logic [PCNT_W-1:0] r_pcnt;
    logic [BYTE_W-1:0] r_o_byte;
    logic              r_o_status;
    logic              r_o_last;

    logic             n_busy;
    logic             n_err;
    logic             n_end;
    logic [CW-1:0]    n_code;
    logic [LEN_W-1:0] n_rem;
    logic [PEND_W-1:0] n_pend;
    logic [PCNT_W-1:0] n_pcnt;
    logic             n_emit;
    logic [BYTE_W-1:0] n_byte;
    logic             n_status;
    logic             n_last;

    // table ram
    logic               w_we;
    logic               w_re;
    logic [IDX_W-1:0]   w_addr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ENTRY_W-1:0] w_rdata;

    logic w_s_accept;
    logic w_out_free;
    logic w_step;
    logic w_finish;
    logic w_job_load;

    assign w_s_accept = i_s_tvalid && o_s_tready;

    always_comb begin
        w_we    = 1'b0;
        w_re    = 1'b0;
        w_addr  = r_clr_addr;
        w_wdata = '0;
        if (r_clr_active) begin
            w_we = 1'b1;
        end else if (w_s_accept) begin
            unique case (w_mode)
                MODE_LOAD: begin
                    w_we    = (w_index <= END_SLOT);
                    w_addr  = w_index;
                    w_wdata = {w_val, w_len_clamp};
                end
                MODE_ENCODE: begin
                    w_re   = 1'b1;
                    w_addr = {1'b0, w_sample};
                end
                MODE_END: begin
                    w_re   = 1'b1;
                    w_addr = END_SLOT;
                end
                default: begin
                    w_re = 1'b0;
                end
            endcase
        end
    end

    hufbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // left align the looked up code in the emitter register
    logic [LEN_W-1:0]  w_rd_len;
    logic [VAL_W-1:0]  w_rd_val;
    logic [SH_W-1:0]   w_align_sh;
    logic [CW_EXT-1:0] w_shifted;
    logic [CW-1:0]     w_aligned;

    assign w_rd_len   = w_rdata[LEN_W-1:0];
    assign w_rd_val   = w_rdata[ENTRY_W-1:LEN_W];
    assign w_align_sh = SH_W'(CW_EXT) - SH_W'(w_rd_len);
    assign w_shifted  = CW_EXT'(w_rd_val) << w_align_sh;
    assign w_aligned  = w_shifted[CW_EXT-1 -: CW];

    // byte emitter datapath
    logic [BYTE_W-1:0]          w_top;
    logic [PEND_W+BYTE_W-1:0]   w_x;
    logic [3:0]                 w_need;
    logic                       w_full;
    logic [LEN_W-1:0]           w_rem_full;
    logic [BYTE_W-1:0]          w_byte;
    logic [3:0]                 w_abs_sh;
    logic [PEND_W+BYTE_W-1:0]   w_abs;
    logic [PCNT_W-1:0]          w_pcnt_abs;

    assign w_top      = r_code[CW-1 -: BYTE_W];
    assign w_x        = {r_pend, w_top};
    assign w_need     = 4'd8 - {1'b0, r_pcnt};
    assign w_full     = r_rem >= {2'b00, w_need};
    assign w_rem_full = r_rem - {2'b00, w_need};
    assign w_byte     = w_x[r_pcnt +: BYTE_W];
    assign w_abs_sh   = 4'd8 - {1'b0, r_rem[2:0]};
    assign w_abs      = w_x >> w_abs_sh;
    assign w_pcnt_abs = r_pcnt + r_rem[2:0];

    assign w_out_free = !r_o_valid || i_m_tready;
    assign w_step     = r_busy && w_out_free;
    assign w_finish   = w_step && (r_err || !w_full || (w_rem_full == '0));

    always_comb begin
        n_busy   = r_busy;
        n_err    = r_err;
        n_end    = r_end;
        n_code   = r_code;
        n_rem    = r_rem;
        n_pend   = r_pend;
        n_pcnt   = r_pcnt;
        n_emit   = 1'b0;
        n_byte   = '0;
        n_status = 1'b0;
        n_last   = 1'b0;

        if (w_step) begin
            if (r_err) begin
                n_emit   = 1'b1;
                n_status = 1'b1;
                n_last   = 1'b1;
            end else if (w_full) begin
                n_emit   = 1'b1;
                n_byte   = w_byte;
                n_last   = r_end ? (w_rem_full == '0) : (w_rem_full < LEN_W'(BYTE_W));
                n_code   = r_code << w_need;
                n_rem    = w_rem_full;
                n_pend   = '0;
                n_pcnt   = '0;
            end else begin
                n_rem    = '0;
                if (r_end) begin
                    n_emit = (r_rem != '0) || (r_pcnt != '0);
                    n_byte = w_byte;
                    n_last = 1'b1;
                    n_pend = '0;
                    n_pcnt = '0;
                end else begin
                    n_pend = w_abs[PEND_W-1:0];
                    n_pcnt = w_pcnt_abs;
                end
            end
            if (w_finish) begin
                n_busy = 1'b0;
            end
        end

        if (w_job_load) begin
            n_busy = 1'b1;
            n_err  = (w_rd_len == '0);
            n_end  = r_rd_end;
            n_code = w_aligned;
            n_rem  = w_rd_len;
        end
    end

    assign w_job_load = r_rd_valid && (!r_busy || w_finish);
    assign o_s_tready = !r_clr_active && (!r_rd_valid || w_job_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_rd_valid   <= 1'b0;
            r_rd_end     <= 1'b0;
            r_busy       <= 1'b0;
            r_err        <= 1'b0;
            r_end        <= 1'b0;
            r_pend       <= '0;
            r_pcnt       <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == END_SLOT) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (w_s_accept) begin
                r_rd_valid <= w_re;
                r_rd_end   <= (w_mode == MODE_END);
            end else if (w_job_load) begin
                r_rd_valid <= 1'b0;
            end
            r_busy <= n_busy;
            r_err  <= n_err;
            r_end  <= n_end;
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
            if (w_out_free) begin
                r_o_valid <= n_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_code <= n_code;
        r_rem  <= n_rem;
        if (w_out_free && n_emit) begin
            r_o_byte   <= n_byte;
            r_o_status <= n_status;
            r_o_last   <= n_last;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_byte;
    assign o_m_tuser  = r_o_status;
    assign o_m_tlast  = r_o_last;

endmodule

// ----- tb/tb_huffman_table_bit_packer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_table_bit_packer_top
// self-checking bench for the huffman table bit packer
//
// table loads, sample encodes and end-of-stream flushes are sent over the s
// stream. Each accepted transaction is run through a local copy of the code
// table and bit accumulator to predict the bytes on the m stream, which are
// checked in order field by field. A short directed sequence comes first,
// then random phases with different amounts of sender idling and receiver
// stalling, drained between phases.
// ----------------------------------------------------------------------------
module tb_huffman_table_bit_packer_top;

    import hufbp_pkg::*;

    localparam int MAX_CODE_LEN = 32;
    localparam int STALL_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 40;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [IDX_W-1:0]           idx;
        logic [LEN_W-1:0]           len;
        logic [VAL_W-1:0]           code;
        logic signed [SAMPLE_W-1:0] sample;
    } t_packer_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              status;
        logic              last;
    } t_packed_byte;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata;
    logic [MODE_W-1:0]      i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [BYTE_W-1:0]      o_m_tdata;
    logic [0:0]             o_m_tuser;
    logic                   o_m_tlast;

    huffman_table_bit_packer_top #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    t_packer_cmd        packer_cmds[$];
    t_packed_byte       expected_bytes[$];
    t_packer_cmd        cmd_on_bus;
    t_packer_cmd        next_cmd;
    t_packed_byte       want;
    logic [IN_DATA_W-1:0] word;

    logic [LEN_W-1:0]   tbl_len  [TABLE_ENTRIES];
    logic [VAL_W-1:0]   tbl_code [TABLE_ENTRIES];
    logic [BYTE_W-1:0]  acc_bits;
    int                 acc_cnt;

    logic [BYTE_W-1:0]  alphabet [16];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  cmds_queued;
    int  cmds_taken;
    int  mismatches;
    int  idle_cycles;
    bit  s_taken;
    bit  m_taken;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // append one predicted result to the scoreboard queue
    task automatic expect_byte(input t_packed_byte b);
        begin
            expected_bytes.insert(expected_bytes.size(), b);
        end
    endtask

    // local table and accumulator, producing the bytes one transaction causes
    task automatic predict_packer(input t_packer_cmd c);
        int                slot;
        int                n;
        int                i;
        logic [BYTE_W-1:0] res [5];
        t_packed_byte      b;
        begin
            n = 0;
            if (c.mode == MODE_LOAD) begin
                if (c.idx < TABLE_ENTRIES) begin
                    tbl_len[c.idx]  = (c.len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : c.len;
                    tbl_code[c.idx] = c.code;
                end
            end else if (c.mode == MODE_ENCODE || c.mode == MODE_END) begin
                slot = (c.mode == MODE_ENCODE) ? int'({1'b0, c.sample}) : int'(END_SLOT);
                if (tbl_len[slot] == 0) begin
                    b.data   = '0;
                    b.status = 1'b1;
                    b.last   = 1'b1;
                    expect_byte(b);
                end else begin
                    for (i = int'(tbl_len[slot]) - 1; i >= 0; i--) begin
                        acc_bits = {acc_bits[BYTE_W-2:0], tbl_code[slot][i]};
                        acc_cnt++;
                        if (acc_cnt == 8) begin
                            res[n] = acc_bits;
                            n++;
                            acc_bits = '0;
                            acc_cnt  = 0;
                        end
                    end
                    if (c.mode == MODE_END) begin
                        if (acc_cnt > 0) begin
                            res[n] = acc_bits << (8 - acc_cnt);
                            n++;
                        end
                        acc_bits = '0;
                        acc_cnt  = 0;
                    end
                    for (i = 0; i < n; i++) begin
                        b.data   = res[i];
                        b.status = 1'b0;
                        b.last   = (i == n - 1);
                        expect_byte(b);
                    end
                end
            end
        end
    endtask

    task automatic add_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                           input logic [LEN_W-1:0] len, input logic [VAL_W-1:0] code,
                           input logic [SAMPLE_W-1:0] smp);
        t_packer_cmd c;
        begin
            c.mode   = mode;
            c.idx    = idx;
            c.len    = len;
            c.code   = code;
            c.sample = smp;
            packer_cmds.insert(packer_cmds.size(), c);
            cmds_queued++;
        end
    endtask

    function automatic logic [LEN_W-1:0] rand_len();
        int r;
        begin
            r = $urandom_range(99);
            if (r < 70)      rand_len = LEN_W'($urandom_range(8, 1));
            else if (r < 82) rand_len = LEN_W'($urandom_range(32, 9));
            else if (r < 92) rand_len = LEN_W'($urandom_range(63, 33));
            else             rand_len = '0;
        end
    endfunction

    task automatic drain();
        begin
            while (cmds_taken != cmds_queued || expected_bytes.size() != 0)
                @(posedge i_clk);
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_cmds);
        int k;
        int r;
        logic [IDX_W-1:0] idx;
        begin
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            for (k = 0; k < 16; k++) begin
                alphabet[k] = BYTE_W'($urandom);
                add_cmd(MODE_LOAD, {1'b0, alphabet[k]}, LEN_W'($urandom_range(6, 1)),
                        $urandom, SAMPLE_W'($urandom));
            end
            add_cmd(MODE_LOAD, END_SLOT, LEN_W'($urandom_range(12, 1)), $urandom,
                    SAMPLE_W'($urandom));
            for (k = 0; k < n_cmds; k++) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    r = $urandom_range(99);
                    if (r < 60)      idx = {1'b0, alphabet[$urandom_range(15)]};
                    else if (r < 70) idx = END_SLOT;
                    else if (r < 90) idx = IDX_W'($urandom_range(255));
                    else             idx = IDX_W'($urandom_range(511, 257));
                    add_cmd(MODE_LOAD, idx, rand_len(), $urandom, SAMPLE_W'($urandom));
                end else if (r < 85) begin
                    add_cmd(MODE_ENCODE, IDX_W'($urandom), LEN_W'($urandom), $urandom,
                            ($urandom_range(9) == 0) ? BYTE_W'($urandom)
                                                     : alphabet[$urandom_range(15)]);
                end else if (r < 95) begin
                    add_cmd(MODE_END, IDX_W'($urandom), LEN_W'($urandom), $urandom,
                            SAMPLE_W'($urandom));
                end else begin
                    add_cmd(MODE_UNUSED, IDX_W'($urandom), LEN_W'($urandom), $urandom,
                            SAMPLE_W'($urandom));
                end
            end
            drain();
        end
    endtask

    // s side driver and m side ready
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || s_taken) begin
                if (packer_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_cmd   = packer_cmds.pop_front();
                    cmd_on_bus = next_cmd;
                    word       = '0;
                    word[IDX_LSB    +: IDX_W]    = next_cmd.idx;
                    word[LEN_LSB    +: LEN_W]    = next_cmd.len;
                    word[VAL_LSB    +: VAL_W]    = next_cmd.code;
                    word[SAMPLE_LSB +: SAMPLE_W] = next_cmd.sample;
                    i_s_tdata  <= word;
                    i_s_tuser  <= next_cmd.mode;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // prediction, m side checking and watchdog
    always @(posedge i_clk) begin
        s_taken = i_rst_n && i_s_tvalid && o_s_tready;
        m_taken = i_rst_n && o_m_tvalid && i_m_tready;
        if (s_taken) begin
            predict_packer(cmd_on_bus);
            cmds_taken++;
        end
        if (m_taken) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected transaction: out_byte %02h status %0b last %0b",
                       o_m_tdata, o_m_tuser, o_m_tlast);
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (o_m_tdata !== want.data) begin
                    $error("out_byte expected %02h actual %02h", want.data, o_m_tdata);
                    mismatches++;
                end
                if (o_m_tuser[0] !== want.status) begin
                    $error("status expected %0b actual %0b", want.status, o_m_tuser[0]);
                    mismatches++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last expected %0b actual %0b", want.last, o_m_tlast);
                    mismatches++;
                end
            end
        end
        if (s_taken || m_taken || (!i_s_tvalid && expected_bytes.size() == 0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;
        i_m_tready     = 1'b0;
        cmd_on_bus     = '0;
        acc_bits       = '0;
        acc_cnt        = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cmds_queued    = 0;
        cmds_taken     = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        s_taken        = 1'b0;
        m_taken        = 1'b0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            tbl_len[k]  = '0;
            tbl_code[k] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: missing sample and missing end code
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'h00);
        add_cmd(MODE_END, 9'd0, 6'd0, 32'd0, 8'h00);
        add_cmd(MODE_LOAD, 9'd128, 6'd32, 32'hFFFF_FFFF, 8'h00);
        add_cmd(MODE_LOAD, 9'd127, 6'd1, 32'h0000_0001, 8'h00);
        add_cmd(MODE_LOAD, END_SLOT, 6'd3, 32'h0000_0005, 8'h00);
        // out of range slots are ignored
        add_cmd(MODE_LOAD, 9'd300, 6'd5, 32'h0000_0000, 8'h00);
        add_cmd(MODE_LOAD, 9'd511, 6'd63, 32'hFFFF_FFFF, 8'hFF);
        // length above the maximum is clamped
        add_cmd(MODE_LOAD, 9'd0, 6'd63, 32'h8000_0001, 8'h00);
        add_cmd(MODE_LOAD, 9'd255, 6'd7, 32'h0000_0000, 8'h00);
        add_cmd(MODE_UNUSED, 9'h1FF, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'h80);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'h7F);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'hFF);
        add_cmd(MODE_END, 9'd0, 6'd0, 32'd0, 8'h00);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'h7F);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'h00);
        // absent sample leaves the accumulator alone
        add_cmd(MODE_LOAD, 9'd255, 6'd0, 32'h0000_0000, 8'h00);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'hFF);
        add_cmd(MODE_END, 9'd0, 6'd0, 32'd0, 8'h00);
        // stream ending on a byte boundary, then absent end code
        add_cmd(MODE_LOAD, END_SLOT, 6'd8, 32'h0000_005A, 8'h00);
        add_cmd(MODE_END, 9'd0, 6'd0, 32'd0, 8'h00);
        add_cmd(MODE_LOAD, END_SLOT, 6'd0, 32'h0000_0000, 8'h00);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'h7F);
        add_cmd(MODE_END, 9'd0, 6'd0, 32'd0, 8'h00);
        // seven pending bits plus a full length end code: five bytes
        add_cmd(MODE_LOAD, 9'd1, 6'd6, 32'h0000_0015, 8'h00);
        add_cmd(MODE_ENCODE, 9'd0, 6'd0, 32'd0, 8'h01);
        add_cmd(MODE_LOAD, END_SLOT, 6'd40, 32'hDEAD_BEEF, 8'h00);
        add_cmd(MODE_END, 9'd0, 6'd0, 32'd0, 8'h00);
        drain();

        run_random_phase(0, 0, 100);
        run_random_phase(60, 0, 100);
        run_random_phase(0, 60, 100);
        run_random_phase(35, 35, 100);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
